/* hw/rtl/spring_follower_with_retract_assert.svh */
// Assertion macros for the spring follower checker.
// Needs clk and rst_n in the scope where the macros are used.
`ifndef SPRING_FOLLOWER_WITH_RETRACT_ASSERT_SVH
`define SPRING_FOLLOWER_WITH_RETRACT_ASSERT_SVH

// same-cycle implication
`define SFR_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("spring follower check failed");

// next-cycle implication
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("spring follower check failed");

`endif

/* hw/rtl/sfr_pkg.sv */
// Shared types, codes and helpers for the spring follower.
// No dependencies.
package sfr_pkg;

    typedef enum logic [5:0] {
        S_IDLE, S_DIFF, S_SQ_MUL, S_SQ_ACC, S_DIST_GO, S_DIST_WAIT,
        S_RATIO_GO, S_RATIO_WAIT, S_EXT_MUL, S_EXT_USE,
        S_A_MUL, S_A_USE, S_B_MUL, S_B_USE, S_V_MUL, S_V_USE, S_P_MUL, S_P_USE,
        S_MS1_MUL, S_MS1_USE, S_MS2_MUL, S_MS2_USE, S_MS3_MUL, S_MS3_USE,
        S_VS_MUL, S_VS_ACC, S_SPD_GO, S_SPD_WAIT,
        S_CL_MUL, S_CL_GO, S_CL_WAIT,
        S_TAB0, S_TAB1, S_EX_MUL, S_EX_USE, S_PL_MUL, S_PL_USE,
        S_O_MUL, S_O_USE, S_DONE
    } state_t;

    typedef enum logic {
        IT_SQRT,
        IT_DIV
    } iter_mode_t;

    typedef struct packed {
        logic       start;
        iter_mode_t mode;
    } iter_req_t;

    typedef logic signed [67:0] wide_t;

    localparam logic [1:0] ST_MOVED      = 2'd0;
    localparam logic [1:0] ST_HELD       = 2'd1;
    localparam logic [1:0] ST_SPRING_ERR = 2'd2;
    localparam logic [1:0] ST_REINIT     = 2'd3;

    localparam logic [1:0] CFG_SQRT_SPRING      = 2'd0;
    localparam logic [1:0] CFG_MAX_DISTANCE     = 2'd1;
    localparam logic [1:0] CFG_RETRACT_STRENGTH = 2'd2;
    localparam logic [1:0] CFG_RETRACT_RATIO    = 2'd3;

    localparam int unsigned EXP_STEP_SHIFT = 5;
    localparam logic [31:0] EXP_STEP_Q30   = 32'd1040706261;
    localparam logic [16:0] INV_E_Q16      = 17'd24109;
    localparam logic [16:0] ONE_Q16        = 17'd65536;

    function automatic logic signed [31:0] sat32(input wide_t x);
        logic signed [31:0] r;
        if (x > 68'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (x < -68'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    // symmetric clamp to +-(2^31 - 1)
    function automatic logic signed [31:0] clamp_d(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v > 33'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -33'sd2147483647)
            r = 32'sh80000001;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

/* hw/rtl/spring_follower_with_retract.sv */
// Spring follower top level: sequencer, state registers, exp table, config.
// Depends on sfr_pkg, sfr_mul, sfr_iter.
//
//  channel | direction | handshake          | beat
//  --------+-----------+--------------------+----------------------------------
//  in      | input     | in_valid/in_stall  | op, target_xyz, retract_xyz, dt
//  out     | output    | out_valid/out_stall| out_xyz, status
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Reinit, spring error and zero-step beats answer in the cycle after acceptance.
// A moving update takes longer, more so when the speed limit engages;
// the bit-serial root/divide unit (32 or 64 steps per use) sets its length.
// Reset clears position, velocity and the started flag and loads config defaults.
// in_stall stays high while an update runs or while a result waits stalled.
module spring_follower_with_retract #(
    parameter int FRAC_BITS       = 16,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               op,
    input  logic signed [31:0] target_x,
    input  logic signed [31:0] target_y,
    input  logic signed [31:0] target_z,
    input  logic signed [31:0] retract_x,
    input  logic signed [31:0] retract_y,
    input  logic signed [31:0] retract_z,
    input  logic [15:0]        delta_time,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [1:0]         status,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import sfr_pkg::*;

    localparam int EXP_SH = FRAC_BITS - EXP_STEP_SHIFT;
    localparam int TAB_AW = $clog2(EXP_TABLE_DEPTH + 1);

    typedef logic [30:0] tab_arr_t [0:EXP_TABLE_DEPTH];

    function automatic tab_arr_t build_tab();
        tab_arr_t    t;
        logic [63:0] p;
        t[0] = 31'h40000000;
        for (int i = 1; i <= EXP_TABLE_DEPTH; i++)
        begin
            p    = 64'(t[i-1]) * 64'(EXP_STEP_Q30) + 64'h20000000;
            t[i] = p[60:30];
        end
        return t;
    endfunction

    localparam tab_arr_t EXP_TAB = build_tab();

    // control and state
    state_t             state_reg, state_next;
    logic [1:0]         idx_reg;
    logic               started_reg;
    logic signed [31:0] pos_reg [4];
    logic signed [31:0] vel_reg [4];
    logic [15:0]        s_reg;
    logic [30:0]        md_reg;
    logic signed [31:0] strength_reg;
    logic [16:0]        rr_reg;
    logic               out_valid_reg;
    logic               accept;
    logic               out_free;
    logic               out_load;

    // payload
    logic signed [31:0] tgt_reg [3];
    logic signed [31:0] rp_reg [3];
    logic [15:0]        dt_reg;
    logic signed [31:0] d_reg [4];
    logic [63:0]        sum_reg;
    logic [31:0]        dist_reg;
    logic [30:0]        ratio_reg;
    logic signed [31:0] ext_reg;
    logic signed [31:0] b_reg;
    logic signed [31:0] acc_reg;
    logic [46:0]        mds_reg;
    logic [37:0]        maxspeed_reg;
    logic [31:0]        speed_reg;
    logic               neg_reg;
    logic [30:0]        t0_reg;
    logic [16:0]        om_reg;
    logic [16:0]        pull_reg;
    logic signed [31:0] o_reg [3];
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic [1:0]         status_reg;

    // shared units
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    iter_req_t          it_req;
    logic [63:0]        it_operand;
    logic [31:0]        it_divisor;
    logic               it_done;
    logic [63:0]        it_result;
    logic [TAB_AW-1:0]  rom_addr;
    logic [30:0]        rom_q;

    // datapath temporaries
    wide_t              pw;
    logic signed [31:0] a_c, b_c, acc1_c, acc_c;
    logic [30:0]        u_c;
    logic [30:0]        tidx_c;
    logic [TAB_AW-1:0]  addr0_c, addr1_c;
    logic [EXP_SH-1:0]  frac_c;
    logic [30:0]        e30_c;
    logic [16:0]        e16_c;
    logic [16:0]        rr_c;
    logic [63:0]        ms_total_c;
    logic [63:0]        mag_c;
    logic signed [31:0] d3_base;

    sfr_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    sfr_iter u_iter (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (it_req),
        .operand (it_operand),
        .divisor (it_divisor),
        .done    (it_done),
        .result  (it_result)
    );

    always_ff @(posedge clk)
    begin
        rom_q <= EXP_TAB[rom_addr];
    end

    assign out_free = !out_valid_reg || !out_stall;
    assign accept   = in_valid && !in_stall;
    // load a result beat: quick answers from idle, or the end of a moving update
    assign out_load = (state_reg == S_IDLE && accept && (op || s_reg == '0 || delta_time == '0))
                      || (state_reg == S_DONE && out_free);

    always_comb
    begin
        pw     = wide_t'(mul_p);
        a_c    = sat32(pw >>> 8);
        b_c    = sat32(wide_t'(a_c) - (wide_t'(vel_reg[idx_reg]) <<< 1));
        acc1_c = sat32(pw >>> 8);
        acc_c  = (idx_reg == 2'd3) ? sat32(wide_t'(acc1_c) + wide_t'(ext_reg)) : acc1_c;
        u_c    = pos_reg[3][31] ? 31'd0 : pos_reg[3][30:0];
        tidx_c = u_c >> EXP_SH;
        if (tidx_c >= 31'(EXP_TABLE_DEPTH))
        begin
            addr0_c = TAB_AW'(EXP_TABLE_DEPTH);
            addr1_c = TAB_AW'(EXP_TABLE_DEPTH);
            frac_c  = '0;
        end
        else
        begin
            addr0_c = tidx_c[TAB_AW-1:0];
            addr1_c = tidx_c[TAB_AW-1:0] + TAB_AW'(1);
            frac_c  = u_c[EXP_SH-1:0];
        end
        e30_c      = t0_reg - 31'(mul_p >>> EXP_SH);
        e16_c      = 17'((32'(e30_c) + 32'd8192) >> 14);
        rr_c       = (rr_reg > ONE_Q16) ? ONE_Q16 : rr_reg;
        ms_total_c = sum_reg + {mul_p[31:0], 32'd0};
        mag_c      = mul_p[65] ? 64'(-mul_p) : 64'(mul_p);
        d3_base    = '0;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && !op && s_reg != '0 && delta_time != '0)
                    state_next = S_DIFF;
            S_DIFF:       state_next = S_SQ_MUL;
            S_SQ_MUL:     state_next = S_SQ_ACC;
            S_SQ_ACC:     state_next = (idx_reg == 2'd3) ? S_DIST_GO : S_SQ_MUL;
            S_DIST_GO:    state_next = S_DIST_WAIT;
            S_DIST_WAIT:  if (it_done) state_next = S_RATIO_GO;
            S_RATIO_GO:   state_next = S_RATIO_WAIT;
            S_RATIO_WAIT: if (it_done) state_next = S_EXT_MUL;
            S_EXT_MUL:    state_next = S_EXT_USE;
            S_EXT_USE:    state_next = S_A_MUL;
            S_A_MUL:      state_next = S_A_USE;
            S_A_USE:      state_next = S_B_MUL;
            S_B_MUL:      state_next = S_B_USE;
            S_B_USE:      state_next = S_V_MUL;
            S_V_MUL:      state_next = S_V_USE;
            S_V_USE:      state_next = S_P_MUL;
            S_P_MUL:      state_next = S_P_USE;
            S_P_USE:      state_next = (idx_reg == 2'd3) ? S_MS1_MUL : S_A_MUL;
            S_MS1_MUL:    state_next = S_MS1_USE;
            S_MS1_USE:    state_next = S_MS2_MUL;
            S_MS2_MUL:    state_next = S_MS2_USE;
            S_MS2_USE:    state_next = S_MS3_MUL;
            S_MS3_MUL:    state_next = S_MS3_USE;
            S_MS3_USE:    state_next = S_VS_MUL;
            S_VS_MUL:     state_next = S_VS_ACC;
            S_VS_ACC:     state_next = (idx_reg == 2'd2) ? S_SPD_GO : S_VS_MUL;
            S_SPD_GO:     state_next = S_SPD_WAIT;
            S_SPD_WAIT:
                if (it_done)
                    state_next = ({6'd0, it_result[31:0]} > maxspeed_reg) ? S_CL_MUL : S_TAB0;
            S_CL_MUL:     state_next = S_CL_GO;
            S_CL_GO:      state_next = S_CL_WAIT;
            S_CL_WAIT:
                if (it_done)
                    state_next = (idx_reg == 2'd2) ? S_TAB0 : S_CL_MUL;
            S_TAB0:       state_next = S_TAB1;
            S_TAB1:       state_next = S_EX_MUL;
            S_EX_MUL:     state_next = S_EX_USE;
            S_EX_USE:     state_next = S_PL_MUL;
            S_PL_MUL:     state_next = S_PL_USE;
            S_PL_USE:     state_next = S_O_MUL;
            S_O_MUL:      state_next = S_O_USE;
            S_O_USE:      state_next = (idx_reg == 2'd2) ? S_DONE : S_O_MUL;
            S_DONE:       if (out_free) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    // unit control
    always_comb
    begin
        mul_a      = '0;
        mul_b      = '0;
        it_req     = '{start: 1'b0, mode: IT_SQRT};
        it_operand = sum_reg;
        it_divisor = speed_reg;
        rom_addr   = addr0_c;
        in_stall   = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
        case (state_reg)
            S_SQ_MUL:
            begin
                mul_a = 33'(d_reg[idx_reg]);
                mul_b = 33'(d_reg[idx_reg]);
            end
            S_DIST_GO:
                it_req = '{start: 1'b1, mode: IT_SQRT};
            S_RATIO_GO:
            begin
                it_req     = '{start: 1'b1, mode: IT_DIV};
                it_operand = 64'(dist_reg) << FRAC_BITS;
                it_divisor = (md_reg == '0) ? 32'd1 : {1'b0, md_reg};
            end
            S_EXT_MUL:
            begin
                mul_a = 33'(ratio_reg);
                mul_b = 33'(strength_reg);
            end
            S_A_MUL:
            begin
                mul_a = 33'(d_reg[idx_reg]);
                mul_b = 33'(s_reg);
            end
            S_B_MUL:
            begin
                mul_a = 33'(b_reg);
                mul_b = 33'(s_reg);
            end
            S_V_MUL:
            begin
                mul_a = 33'(acc_reg);
                mul_b = 33'(dt_reg);
            end
            S_P_MUL:
            begin
                mul_a = 33'(vel_reg[idx_reg]);
                mul_b = 33'(dt_reg);
            end
            S_MS1_MUL:
            begin
                mul_a = 33'(md_reg);
                mul_b = 33'(s_reg);
            end
            S_MS2_MUL:
            begin
                mul_a = 33'(mds_reg[31:0]);
                mul_b = 33'(INV_E_Q16);
            end
            S_MS3_MUL:
            begin
                mul_a = 33'(mds_reg[46:32]);
                mul_b = 33'(INV_E_Q16);
            end
            S_VS_MUL:
            begin
                mul_a = 33'(vel_reg[idx_reg]);
                mul_b = 33'(vel_reg[idx_reg]);
            end
            S_SPD_GO:
                it_req = '{start: 1'b1, mode: IT_SQRT};
            S_CL_MUL:
            begin
                mul_a = 33'(vel_reg[idx_reg]);
                mul_b = 33'(maxspeed_reg[31:0]);
            end
            S_CL_GO:
            begin
                it_req     = '{start: 1'b1, mode: IT_DIV};
                it_operand = mag_c;
                it_divisor = speed_reg;
            end
            S_TAB0:
                rom_addr = addr0_c;
            S_TAB1:
                rom_addr = addr1_c;
            S_EX_MUL:
            begin
                mul_a = 33'(t0_reg - rom_q);
                mul_b = 33'(frac_c);
            end
            S_PL_MUL:
            begin
                mul_a = 33'(om_reg);
                mul_b = 33'(rr_c);
            end
            S_O_MUL:
            begin
                mul_a = 33'(rp_reg[idx_reg]) - 33'(pos_reg[idx_reg]);
                mul_b = 33'(pull_reg);
            end
            default:
                mul_a = '0;
        endcase
    end

    // control, state vector and config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            s_reg         <= 16'd256;
            md_reg        <= 31'd65536;
            strength_reg  <= '0;
            rr_reg        <= '0;
            for (int k = 0; k < 4; k++)
            begin
                pos_reg[k] <= '0;
                vel_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_SQRT_SPRING:      s_reg        <= cfg_data[15:0];
                    CFG_MAX_DISTANCE:     md_reg       <= cfg_data[30:0];
                    CFG_RETRACT_STRENGTH: strength_reg <= cfg_data;
                    CFG_RETRACT_RATIO:    rr_reg       <= cfg_data[16:0];
                    default:              rr_reg       <= rr_reg;
                endcase
            end

            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (accept)
                    begin
                        if (op)
                            started_reg <= 1'b0;
                        else if (s_reg != '0 && !started_reg)
                        begin
                            pos_reg[0]  <= target_x;
                            pos_reg[1]  <= target_y;
                            pos_reg[2]  <= target_z;
                            pos_reg[3]  <= d3_base;
                            for (int k = 0; k < 4; k++)
                                vel_reg[k] <= '0;
                            started_reg <= 1'b1;
                        end
                    end
                end
                S_SQ_ACC, S_P_USE, S_VS_ACC, S_O_USE:
                    idx_reg <= (state_next == S_MS1_MUL || state_next == S_SPD_GO
                                || state_next == S_DONE) ? 2'd0 : idx_reg + 2'd1;
                S_V_USE:
                    vel_reg[idx_reg] <= sat32(wide_t'(vel_reg[idx_reg]) + (pw >>> 16));
                S_CL_WAIT:
                    if (it_done)
                    begin
                        vel_reg[idx_reg] <= neg_reg ? -signed'(it_result[31:0])
                                                    : signed'(it_result[31:0]);
                        idx_reg <= (idx_reg == 2'd2) ? 2'd0 : idx_reg + 2'd1;
                    end
                default:
                    idx_reg <= idx_reg;
            endcase

            if (state_reg == S_P_USE)
                pos_reg[idx_reg] <= sat32(wide_t'(pos_reg[idx_reg]) + (pw >>> 16));
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    tgt_reg[0] <= target_x;
                    tgt_reg[1] <= target_y;
                    tgt_reg[2] <= target_z;
                    rp_reg[0]  <= retract_x;
                    rp_reg[1]  <= retract_y;
                    rp_reg[2]  <= retract_z;
                    dt_reg     <= delta_time;
                    if (!op && s_reg != '0 && !started_reg)
                    begin
                        out_x_reg <= target_x;
                        out_y_reg <= target_y;
                        out_z_reg <= target_z;
                    end
                    else
                    begin
                        out_x_reg <= pos_reg[0];
                        out_y_reg <= pos_reg[1];
                        out_z_reg <= pos_reg[2];
                    end
                    if (op)
                        status_reg <= ST_REINIT;
                    else if (s_reg == '0)
                        status_reg <= ST_SPRING_ERR;
                    else
                        status_reg <= ST_HELD;
                end
            S_DIFF:
            begin
                for (int k = 0; k < 3; k++)
                    d_reg[k] <= clamp_d(33'(tgt_reg[k]) - 33'(pos_reg[k]));
                d_reg[3] <= clamp_d(-33'(pos_reg[3]));
                sum_reg  <= '0;
            end
            S_SQ_ACC, S_VS_ACC:
                sum_reg <= sum_reg + mul_p[63:0];
            S_DIST_WAIT:
                if (it_done)
                    dist_reg <= it_result[31:0];
            S_RATIO_WAIT:
                if (it_done)
                    ratio_reg <= (it_result > 64'h7FFFFFFF) ? 31'h7FFFFFFF : it_result[30:0];
            S_EXT_USE:
                ext_reg <= sat32(pw >>> FRAC_BITS);
            S_A_USE:
                b_reg <= b_c;
            S_B_USE:
                acc_reg <= acc_c;
            S_MS1_USE:
                mds_reg <= mul_p[46:0];
            S_MS2_USE:
                sum_reg <= mul_p[63:0];
            S_MS3_USE:
            begin
                maxspeed_reg <= ms_total_c[61:24];
                sum_reg      <= '0;
            end
            S_SPD_WAIT:
                if (it_done)
                    speed_reg <= it_result[31:0];
            S_CL_GO:
                neg_reg <= mul_p[65];
            S_TAB1:
                t0_reg <= rom_q;
            S_EX_USE:
                om_reg <= ONE_Q16 - e16_c;
            S_PL_USE:
                pull_reg <= mul_p[32:16];
            S_O_USE:
                o_reg[idx_reg] <= sat32(wide_t'(pos_reg[idx_reg]) + (pw >>> 16));
            S_DONE:
                if (out_free)
                begin
                    out_x_reg  <= o_reg[0];
                    out_y_reg  <= o_reg[1];
                    out_z_reg  <= o_reg[2];
                    status_reg <= ST_MOVED;
                end
            default:
                dt_reg <= dt_reg;
        endcase
    end

    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign status    = status_reg;
endmodule

/* hw/rtl/sfr_mul.sv */
// Shared signed 33x33 multiplier with registered product.
// Depends on nothing.
module sfr_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);
    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;
endmodule

/* hw/rtl/sfr_iter.sv */
// Bit-serial square root (32 steps) and unsigned 64/32 divider (64 steps).
// Depends on sfr_pkg.
module sfr_iter (
    input  logic              clk,
    input  logic              rst_n,
    input  sfr_pkg::iter_req_t req,
    input  logic [63:0]       operand,
    input  logic [31:0]       divisor,
    output logic              done,
    output logic [63:0]       result
);
    import sfr_pkg::*;

    logic             busy_reg;
    logic             done_reg;
    logic [5:0]       cnt_reg;
    iter_mode_t       mode_reg;
    logic [63:0]      x_reg;
    logic [34:0]      rem_reg;
    logic [63:0]      res_reg;
    logic [31:0]      div_reg;
    logic [34:0]      rem_sh;
    logic [34:0]      trial;
    logic             take;
    logic [5:0]       last;

    always_comb
    begin
        if (mode_reg == IT_SQRT)
        begin
            rem_sh = {rem_reg[32:0], x_reg[63:62]};
            trial  = {1'b0, res_reg[31:0], 2'b01};
            last   = 6'd31;
        end
        else
        begin
            rem_sh = {rem_reg[33:0], x_reg[63]};
            trial  = {3'b000, div_reg};
            last   = 6'd63;
        end
        take = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == last)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            mode_reg <= req.mode;
            x_reg    <= operand;
            div_reg  <= divisor;
            rem_reg  <= '0;
            res_reg  <= '0;
        end
        else if (busy_reg)
        begin
            x_reg   <= (mode_reg == IT_SQRT) ? {x_reg[61:0], 2'b00} : {x_reg[62:0], 1'b0};
            rem_reg <= take ? (rem_sh - trial) : rem_sh;
            res_reg <= {res_reg[62:0], take};
        end
    end

    assign done   = done_reg;
    assign result = res_reg;
endmodule

/* hw/rtl/sfr_checker.sv */
// Port-level checks for the spring follower, bound onto the top level.
// Depends on sfr_pkg and spring_follower_with_retract_assert.svh.
`include "spring_follower_with_retract_assert.svh"

module sfr_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               op,
    input logic [15:0]        delta_time,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] out_x,
    input logic [1:0]         status
);
    import sfr_pkg::*;

    // hold a stalled result beat
    `SFR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x))

    // accept only when the result slot is free
    `SFR_ASSERT_NOW(a_slot_free, in_valid && !in_stall, !(out_valid && out_stall))

    // reinit answers in the next cycle
    `SFR_ASSERT_NEXT(a_reinit, in_valid && !in_stall && op,
        out_valid && status == ST_REINIT)

    // zero step answers in the next cycle, held or spring error
    `SFR_ASSERT_NEXT(a_zero_step, in_valid && !in_stall && !op && delta_time == 16'd0,
        out_valid && (status == ST_HELD || status == ST_SPRING_ERR))
endmodule

bind spring_follower_with_retract sfr_checker u_sfr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .op         (op),
    .delta_time (delta_time),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_x      (out_x),
    .status     (status)
);

/* verif/tb_spring_follower_with_retract.sv */
// Self-checking testbench for the spring follower with retract blend.
// Depends on sfr_pkg and spring_follower_with_retract; holds its own predictor.
`timescale 1ns / 100ps

module tb_spring_follower_with_retract;
    import sfr_pkg::*;

    localparam int FRAC = 16;
    localparam int EXP_DEPTH = 256;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic op = 1'b0;
    logic signed [31:0] target_x = '0, target_y = '0, target_z = '0;
    logic signed [31:0] retract_x = '0, retract_y = '0, retract_z = '0;
    logic [15:0] delta_time = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [31:0] out_x, out_y, out_z;
    logic [1:0] status;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;

    spring_follower_with_retract uut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    typedef struct packed {
        logic signed [31:0] x, y, z;
        logic [1:0] st;
    } point_beat_t;

    typedef struct {
        logic op;
        logic signed [31:0] tx, ty, tz, rx, ry, rz;
        logic [15:0] dt;
        logic known;
        point_beat_t res;
    } stim_row_t;

    // predictor state and config copy
    logic [15:0] m_spring;
    logic [30:0] m_maxd;
    logic signed [31:0] m_strength;
    logic [16:0] m_ratio;
    logic signed [31:0] m_pos [4];
    logic signed [31:0] m_vel [4];
    logic m_started;
    logic [31:0] exp_tab [EXP_DEPTH+1];

    point_beat_t pending_points [$];
    int errors = 0;
    int n_in = 0, n_out = 0;
    int send_idle = 0, recv_stall = 0;
    bit hold_recv = 0;

    function automatic longint asr(input longint x, input int n);
        return x >>> n;
    endfunction

    function automatic logic signed [31:0] clip32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic longint unsigned root64(input longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned exp_q16(input logic signed [31:0] w);
        longint unsigned u, idx, e30, fr, df;
        u = (w < 0) ? 0 : longint'(w);
        idx = u >> (FRAC - EXP_STEP_SHIFT);
        if (idx >= EXP_DEPTH)
            e30 = exp_tab[EXP_DEPTH];
        else
        begin
            fr = u & ((64'd1 << (FRAC - EXP_STEP_SHIFT)) - 1);
            df = exp_tab[idx] - exp_tab[idx+1];
            e30 = exp_tab[idx] - ((df * fr) >> (FRAC - EXP_STEP_SHIFT));
        end
        return (e30 + (64'd1 << 13)) >> 14;
    endfunction

    function automatic point_beat_t follow_step(input stim_row_t r);
        point_beat_t o;
        longint d [4];
        longint tg [4];
        longint rp [3];
        longint s, dt, v, a, b, acc, ext, diff;
        longint unsigned sum, span, ratio, maxd, mspd, spd, rr, pull;
        o.st = ST_MOVED;
        if (r.op)
        begin
            m_started = 0;
            o.x = m_pos[0]; o.y = m_pos[1]; o.z = m_pos[2]; o.st = ST_REINIT;
            return o;
        end
        if (m_spring == 0)
        begin
            o.x = m_pos[0]; o.y = m_pos[1]; o.z = m_pos[2]; o.st = ST_SPRING_ERR;
            return o;
        end
        tg[0] = r.tx; tg[1] = r.ty; tg[2] = r.tz; tg[3] = 0;
        rp[0] = r.rx; rp[1] = r.ry; rp[2] = r.rz;
        dt = r.dt;
        s = m_spring;
        if (!m_started)
        begin
            for (int i = 0; i < 4; i++)
            begin
                m_pos[i] = 32'(tg[i]);
                m_vel[i] = 0;
            end
            m_started = 1;
        end
        if (dt == 0)
        begin
            o.x = m_pos[0]; o.y = m_pos[1]; o.z = m_pos[2]; o.st = ST_HELD;
            return o;
        end
        sum = 0;
        for (int i = 0; i < 4; i++)
        begin
            v = tg[i] - longint'(m_pos[i]);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483647) v = -64'sd2147483647;
            d[i] = v;
            sum += longint'(v * v);
        end
        span = root64(sum);
        maxd = (m_maxd != 0) ? m_maxd : 1;
        ratio = (span << FRAC) / maxd;
        if (ratio > 64'd2147483647) ratio = 64'd2147483647;
        ext = clip32(asr(longint'(ratio) * longint'(m_strength), FRAC));
        for (int i = 0; i < 4; i++)
        begin
            a = clip32(asr(d[i] * s, 8));
            b = clip32(a - 2 * longint'(m_vel[i]));
            acc = clip32(asr(b * s, 8));
            if (i == 3) acc = clip32(acc + ext);
            m_vel[i] = clip32(longint'(m_vel[i]) + asr(acc * dt, 16));
            m_pos[i] = clip32(longint'(m_pos[i]) + asr(longint'(m_vel[i]) * dt, 16));
        end
        mspd = (longint'(m_maxd) * longint'(m_spring) * longint'(INV_E_Q16)) >> 24;
        sum = 0;
        for (int i = 0; i < 3; i++)
            sum += longint'(longint'(m_vel[i]) * longint'(m_vel[i]));
        spd = root64(sum);
        if (spd > mspd)
            for (int i = 0; i < 3; i++)
                m_vel[i] = 32'((longint'(m_vel[i]) * longint'(mspd)) / longint'(spd));
        rr = (m_ratio > ONE_Q16) ? ONE_Q16 : m_ratio;
        pull = ((65536 - exp_q16(m_pos[3])) * rr) >> 16;
        diff = rp[0] - longint'(m_pos[0]);
        o.x = clip32(longint'(m_pos[0]) + asr(diff * longint'(pull), 16));
        diff = rp[1] - longint'(m_pos[1]);
        o.y = clip32(longint'(m_pos[1]) + asr(diff * longint'(pull), 16));
        diff = rp[2] - longint'(m_pos[2]);
        o.z = clip32(longint'(m_pos[2]) + asr(diff * longint'(pull), 16));
        return o;
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_SQRT_SPRING: m_spring = val[15:0];
            CFG_MAX_DISTANCE: m_maxd = val[30:0];
            CFG_RETRACT_STRENGTH: m_strength = val;
            default: m_ratio = val[16:0];
        endcase
    endtask

    // drive one beat; the beat is taken at the edge where in_stall is low
    task automatic send_beat(input stim_row_t r);
        point_beat_t e;
        while (send_idle > 0 && ($urandom_range(99) < send_idle))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= r.op;
        target_x <= r.tx; target_y <= r.ty; target_z <= r.tz;
        retract_x <= r.rx; retract_y <= r.ry; retract_z <= r.rz;
        delta_time <= r.dt;
        do @(posedge clk); while (in_stall);
        e = follow_step(r);
        if (r.known && e != r.res)
        begin
            errors++;
            $display("%0t predictor disagrees with table row: exp %h %h %h %0d got %h %h %h %0d",
                     $time, r.res.x, r.res.y, r.res.z, r.res.st, e.x, e.y, e.z, e.st);
        end
        pending_points.push_back(e);
        n_in++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_points.size() != 0) @(posedge clk);
        repeat (500) @(posedge clk);
    endtask

    function automatic logic [31:0] rnd_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            2: return $signed($urandom_range(65536)) - 32768;
            default: return 32'($signed($urandom_range(200)) - 100) <<< 16;
        endcase
    endfunction

    function automatic stim_row_t rnd_row();
        stim_row_t r;
        r.known = 0;
        r.op = ($urandom_range(49) == 0);
        r.tx = rnd_coord(); r.ty = rnd_coord(); r.tz = rnd_coord();
        r.rx = rnd_coord(); r.ry = rnd_coord(); r.rz = rnd_coord();
        case ($urandom_range(9))
            0: r.dt = 0;
            1: r.dt = $urandom;
            default: r.dt = $urandom_range(4000, 300);
        endcase
        return r;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        point_beat_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_points.size() == 0)
            begin
                errors++;
                $display("%0t unexpected beat: got %h %h %h %0d",
                         $time, out_x, out_y, out_z, status);
            end
            else
            begin
                e = pending_points.pop_front();
                n_out++;
                if (out_x !== e.x || out_y !== e.y || out_z !== e.z || status !== e.st)
                begin
                    errors++;
                    $display("%0t mismatch: exp %h %h %h %0d got %h %h %h %0d", $time,
                             e.x, e.y, e.z, e.st, out_x, out_y, out_z, status);
                end
            end
        end
    end

    // receiver stall generator
    always @(posedge clk)
    begin
        if (hold_recv)
            out_stall <= 1'b1;
        else
            out_stall <= (recv_stall > 0) && ($urandom_range(99) < recv_stall);
    end

    initial
    begin
        #50ms;
        $display("spring_follower_with_retract: mismatch");
        $finish;
    end

    initial
    begin
        stim_row_t tbl [$];
        stim_row_t r;
        int ph_send [4] = '{0, 79, 0, 28};
        int ph_recv [4] = '{0, 0, 79, 28};
        m_spring = 256; m_maxd = 65536; m_strength = 0; m_ratio = 0;
        m_started = 0;
        for (int i = 0; i < 4; i++)
        begin
            m_pos[i] = 0;
            m_vel[i] = 0;
        end
        exp_tab[0] = 32'd1 << 30;
        for (int i = 1; i <= EXP_DEPTH; i++)
            exp_tab[i] = (longint'(exp_tab[i-1]) * longint'(EXP_STEP_Q30) + (64'd1 << 29)) >> 30;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed rows: reinit after reset, first update, extremes, zero step
        tbl.push_back('{1, 5, 6, 7, 0, 0, 0, 100, 1, '{0, 0, 0, ST_REINIT}});
        tbl.push_back('{0, 32'sh7FFFFFFF, 32'sh80000000, 3, 0, 0, 0, 0, 1,
                        '{32'sh7FFFFFFF, 32'sh80000000, 3, ST_HELD}});
        tbl.push_back('{0, 32'sh80000000, 32'sh7FFFFFFF, 0, 9, 9, 9, 16'hFFFF, 0, '{0, 0, 0, 0}});
        tbl.push_back('{0, 100 << 16, -5 << 16, 7 << 16, 32'sh7FFFFFFF, 32'sh80000000, 0,
                        1000, 0, '{0, 0, 0, 0}});
        tbl.push_back('{0, 0, 0, 0, 0, 0, 0, 1, 0, '{0, 0, 0, 0}});
        foreach (tbl[i]) send_beat(tbl[i]);
        drain();

        // spring zero error, retract extremes
        write_reg(CFG_SQRT_SPRING, 0);
        r = rnd_row(); r.op = 0;
        send_beat(r);
        drain();
        write_reg(CFG_SQRT_SPRING, 16'hFFFF);
        write_reg(CFG_MAX_DISTANCE, 0);
        write_reg(CFG_RETRACT_STRENGTH, 32'h7FFFFFFF);
        write_reg(CFG_RETRACT_RATIO, 17'h1FFFF);
        for (int i = 0; i < 6; i++) send_beat(rnd_row());
        drain();
        write_reg(CFG_RETRACT_STRENGTH, 32'h80000000);
        write_reg(CFG_MAX_DISTANCE, 31'h7FFFFFFF);
        for (int i = 0; i < 6; i++) send_beat(rnd_row());
        drain();

        // random phases, each with a fresh configuration
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(CFG_SQRT_SPRING, ($urandom_range(7) == 0) ? 0 : $urandom_range(2000, 1));
            write_reg(CFG_MAX_DISTANCE, $urandom_range(3) == 0 ? $urandom : $urandom_range(200 << 16));
            write_reg(CFG_RETRACT_STRENGTH, $signed($urandom_range(1 << 22)) - (1 << 21));
            write_reg(CFG_RETRACT_RATIO, $urandom_range(70000));
            send_idle = ph_send[ph % 4];
            recv_stall = ph_recv[ph % 4];
            for (int i = 0; i < 200; i++)
            begin
                if (ph == 2 && i == 20)
                    fork
                        begin
                            hold_recv = 1;
                            repeat (3000) @(posedge clk);
                            hold_recv = 0;
                        end
                    join_none
                if (ph == 5 && i == 100)
                begin
                    in_valid <= 1'b0;
                    while (pending_points.size() != 0) @(posedge clk);
                end
                send_beat(rnd_row());
            end
            drain();
        end
        send_idle = 0;
        recv_stall = 0;
        drain();

        $display("covered %0d input beats and %0d results over several config settings",
                 n_in, n_out);
        if (errors == 0 && pending_points.size() == 0)
            $display("spring_follower_with_retract: match");
        else
            $display("spring_follower_with_retract: mismatch");
        $finish;
    end
endmodule
